>>> sv/conv3x3_replicate_border_defines.svh
// Assertion macros for the 3x3 convolution block checkers.
`ifndef CONV3X3_REPLICATE_BORDER_DEFINES_SVH
`define CONV3X3_REPLICATE_BORDER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define C3RB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c3rb check failed");

// Next-cycle implication, off while reset is asserted.
`define C3RB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c3rb check failed");

// Next-cycle implication, also checked through reset.
`define C3RB_ASSERT_NXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c3rb check failed");

`endif

>>> sv/c3rb_pkg.sv
// Shared types and constants for the 3x3 convolution block.
package c3rb_pkg;

  localparam int OUT_W       = 20;
  localparam int OUT_TDATA_W = 24;
  localparam int KROW_W      = 24;
  localparam int SIZE_W      = 11;
  localparam int ROW_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [SIZE_W-1:0] HEIGHT_LIMIT  = 11'd1024;
  localparam logic [SIZE_W-1:0] FRAME_W_RESET = 11'd640;
  localparam logic [SIZE_W-1:0] FRAME_H_RESET = 11'd480;

  localparam logic [KROW_W-1:0] KTOP_RESET = 24'hFFFFFF;
  localparam logic [KROW_W-1:0] KMID_RESET = 24'hFF09FF;
  localparam logic [KROW_W-1:0] KBOT_RESET = 24'hFFFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT   = 3'd4;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = 2;
  localparam int OFIFO_CNT_W = 3;

  typedef struct packed {
    logic valid;
    logic dup;
    logic last_in_run;
    logic last_of_frame;
  } job_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last_in_run;
    logic             last_of_frame;
  } res_t;

endpackage

>>> sv/c3rb_ram.sv
// Generic simple dual-port RAM with registered read.
module c3rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/c3rb_window.sv
// Line store read-modify-write, raster counters and the 3x3 pixel window.
module c3rb_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               restart,
  input  logic                               in_fire,
  input  logic                               in_func,
  input  logic [PIXEL_BITS-1:0]              in_pix,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     frame_w,
  input  logic [c3rb_pkg::SIZE_W-1:0]        frame_h,
  output logic                               can_take,
  output c3rb_pkg::job_t                     job,
  output logic [9*PIXEL_BITS-1:0]            win
);

  localparam int P  = PIXEL_BITS;
  localparam int EW = 2 * PIXEL_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = c3rb_pkg::ROW_W;
  localparam int SW = c3rb_pkg::SIZE_W;

  // raster position
  logic [AW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [WW-1:0] drain_r;

  // stage 1: item waiting for its line store entry
  logic          s1_valid_r;
  logic          s1_pixel_r;
  logic [P-1:0]  s1_pix_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_sel_older_r;
  logic          s1_load_left_r;
  logic          s1_emit1_r;
  logic          s1_emit2_r;
  logic          s1_lof_r;

  logic          fwd_hit_r;
  logic [EW-1:0] fwd_data_r;
  logic [EW-1:0] save_r;
  logic [P-1:0]  win_r [3][3];
  c3rb_pkg::job_t job_r;
  logic          dup_pend_r;

  logic          last_col;
  logic          row_last;
  logic          drain_live;
  logic [WW-1:0] d;
  logic [WW-1:0] d_inc;
  logic [WW-1:0] cr;
  logic [AW-1:0] rd_addr;
  logic          s0_valid;
  logic          consume;
  logic [EW-1:0] ram_q;
  logic [EW-1:0] q;
  logic [P-1:0]  newer;
  logic [P-1:0]  older;
  logic [P-1:0]  new_col [3];
  logic [P-1:0]  left_col [3];
  logic          we;
  logic [EW-1:0] wdata;

  assign consume    = adv && !dup_pend_r;
  assign can_take   = !dup_pend_r;
  assign last_col   = (WW'(col_r) + WW'(1)) == frame_w;
  assign row_last   = (SW'(row_r) + SW'(1)) >= frame_h;
  assign drain_live = drain_r != '0;
  assign d          = frame_w - drain_r;
  assign d_inc      = d + WW'(1);
  assign cr         = (d_inc >= frame_w) ? (frame_w - WW'(1)) : d_inc;
  assign rd_addr    = (in_func == c3rb_pkg::FUNC_DRAIN) ? AW'(cr) : col_r;
  assign s0_valid   = (in_func == c3rb_pkg::FUNC_PIXEL) || drain_live;

  // entry layout: older row in the high half, newer row in the low half
  assign q     = fwd_hit_r ? fwd_data_r : ram_q;
  assign newer = q[P-1:0];
  assign older = q[EW-1:P];
  assign wdata = {newer, s1_pix_r};
  assign we    = consume && s1_valid_r && s1_pixel_r;

  always_comb begin
    new_col[0] = s1_sel_older_r ? older : newer;
    new_col[1] = newer;
    new_col[2] = s1_pixel_r ? s1_pix_r : newer;
    if (s1_pixel_r) begin
      left_col = new_col;
    end else begin
      left_col[0] = s1_sel_older_r ? save_r[EW-1:P] : save_r[P-1:0];
      left_col[1] = save_r[P-1:0];
      left_col[2] = save_r[P-1:0];
    end
  end

  c3rb_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr_r),
    .wdata (wdata),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      drain_r    <= '0;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      job_r      <= '0;
      dup_pend_r <= 1'b0;
    end else begin
      if (restart) begin
        col_r   <= '0;
        row_r   <= '0;
        drain_r <= '0;
      end else if (in_fire) begin
        if (in_func == c3rb_pkg::FUNC_PIXEL) begin
          drain_r <= '0;
          if (last_col) begin
            col_r <= '0;
            if (row_last) begin
              row_r   <= '0;
              drain_r <= frame_w;
            end else begin
              row_r <= row_r + RW'(1);
            end
          end else begin
            col_r <= col_r + AW'(1);
          end
        end else if (drain_live) begin
          drain_r <= drain_r - WW'(1);
        end
      end
      if (adv) begin
        if (dup_pend_r) begin
          // second result of a row end: right column repeated
          job_r      <= '{valid: 1'b1, dup: 1'b1, last_in_run: 1'b1, last_of_frame: 1'b0};
          dup_pend_r <= 1'b0;
        end else begin
          s1_valid_r          <= in_fire && s0_valid;
          job_r.valid         <= s1_valid_r && (s1_emit1_r || s1_emit2_r);
          job_r.dup           <= !s1_emit1_r;
          job_r.last_in_run   <= !(s1_emit1_r && s1_emit2_r);
          job_r.last_of_frame <= s1_lof_r;
          dup_pend_r          <= s1_valid_r && s1_emit1_r && s1_emit2_r;
          if (in_fire) begin
            fwd_hit_r <= we && (s1_addr_r == rd_addr);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_func == c3rb_pkg::FUNC_PIXEL;
      s1_pix_r   <= in_pix;
      s1_addr_r  <= rd_addr;
      fwd_data_r <= wdata;
      if (in_func == c3rb_pkg::FUNC_PIXEL) begin
        s1_sel_older_r <= row_r >= RW'(2);
        s1_load_left_r <= col_r == '0;
        s1_emit1_r     <= (row_r != '0) && (col_r != '0);
        s1_emit2_r     <= (row_r != '0) && last_col;
        s1_lof_r       <= 1'b0;
      end else begin
        s1_sel_older_r <= frame_h >= SW'(2);
        s1_load_left_r <= drain_r == frame_w;
        s1_emit1_r     <= 1'b1;
        s1_emit2_r     <= 1'b0;
        s1_lof_r       <= drain_r == WW'(1);
      end
    end
    if (consume && s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        if (s1_load_left_r) begin
          win_r[r][0] <= left_col[r];
          win_r[r][1] <= left_col[r];
        end else begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[r][2] <= new_col[r];
      end
      if (s1_pixel_r && s1_load_left_r) begin
        save_r <= wdata;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win[(r*3+c)*P +: P] = win_r[r][c];
      end
    end
  end

  assign job = job_r;

endmodule

>>> sv/c3rb_mac.sv
// Nine parallel multiplies, registered row sums and final sum.
module c3rb_mac #(
  parameter int PIXEL_BITS = 8,
  parameter int COEFF_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  c3rb_pkg::job_t              job,
  input  logic [9*PIXEL_BITS-1:0]     win,
  input  logic [c3rb_pkg::KROW_W-1:0] k_top,
  input  logic [c3rb_pkg::KROW_W-1:0] k_mid,
  input  logic [c3rb_pkg::KROW_W-1:0] k_bot,
  output logic                        res_valid,
  output c3rb_pkg::res_t              res
);

  localparam int P  = PIXEL_BITS;
  localparam int CB = COEFF_BITS;
  localparam int PW = PIXEL_BITS + 1 + COEFF_BITS;
  localparam int RW = PW + 2;
  localparam int SW = PW + 4;
  localparam int KW = (3 * COEFF_BITS > c3rb_pkg::KROW_W) ? 3 * COEFF_BITS : c3rb_pkg::KROW_W;

  logic [KW-1:0]        kext [3];
  logic signed [PW-1:0] prod [3][3];
  logic signed [PW-1:0] p_r  [3][3];
  logic signed [RW-1:0] rs_r [3];
  logic signed [SW-1:0] total;
  c3rb_pkg::job_t       p_job_r;
  c3rb_pkg::job_t       rs_job_r;
  c3rb_pkg::res_t       res_r;
  logic                 res_valid_r;

  assign kext[0] = KW'(k_top);
  assign kext[1] = KW'(k_mid);
  assign kext[2] = KW'(k_bot);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = $signed({1'b0, win[(r*3 + (job.dup ? ((c == 0) ? 1 : 2) : c))*P +: P]})
                     * $signed(kext[r][c*CB +: CB]);
      end
    end
  end

  assign total = SW'(rs_r[0]) + SW'(rs_r[1]) + SW'(rs_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_job_r     <= '0;
      rs_job_r    <= '0;
      res_valid_r <= 1'b0;
    end else if (adv) begin
      p_job_r     <= job;
      rs_job_r    <= p_job_r;
      res_valid_r <= rs_job_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= prod;
      for (int r = 0; r < 3; r++) begin
        rs_r[r] <= RW'(p_r[r][0]) + RW'(p_r[r][1]) + RW'(p_r[r][2]);
      end
      res_r.value         <= c3rb_pkg::OUT_W'(total);
      res_r.last_in_run   <= rs_job_r.last_in_run;
      res_r.last_of_frame <= rs_job_r.last_of_frame;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> sv/c3rb_ofifo.sv
// Small result queue in front of the output channel.
module c3rb_ofifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  c3rb_pkg::res_t push_res,
  input  logic           pop,
  output logic           out_valid,
  output c3rb_pkg::res_t out_res,
  output logic           room
);

  localparam int PTW = c3rb_pkg::OFIFO_PTR_W;
  localparam int CNW = c3rb_pkg::OFIFO_CNT_W;

  c3rb_pkg::res_t mem [c3rb_pkg::OFIFO_DEPTH];
  logic [PTW-1:0] wr_ptr_r;
  logic [PTW-1:0] rd_ptr_r;
  logic [CNW-1:0] count_r;

  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];
  // pipeline freezes once three results wait
  assign room      = count_r < CNW'(c3rb_pkg::OFIFO_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTW'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CNW'(1);
        2'b01:   count_r <= count_r - CNW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_res;
    end
  end

endmodule

>>> sv/conv3x3_replicate_border.sv
// Streaming 3x3 convolution with clamp-to-edge border, top level.
//
//   channel | direction | beat contents
//   in_     | slave     | tdata: pixel_value; tuser: func (0 pixel, 1 drain)
//   out_    | master    | tdata: filtered_value; tlast: last_in_run; tuser: last_of_frame
//   cfg_    | slave     | cfg_index: register number; cfg_data: value
//
// One beat per cycle while the queue has room and no row end's second result is pending.
// out_tvalid follows the accepting edge (line store read at that edge) through the
// window, products, row sums, final sum and result queue registers.
// Line store is one RAM with one read and one write port; a back-to-back hit is forwarded.
// Synchronous reset; line store contents are not cleared.
// Input keeps flowing while up to two results wait in the 4-entry result queue.
module conv3x3_replicate_border #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8,
  parameter int COEFF_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]      in_tdata,   // [PIXEL_BITS-1:0] pixel_value
  input  logic                                 in_tuser,   // [0] func
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [c3rb_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [19:0] filtered_value
  output logic                                 out_tlast,
  output logic                                 out_tuser,  // [0] last_of_frame
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [c3rb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [c3rb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int WW      = $clog2(MAX_WIDTH+1);
  localparam int SW      = c3rb_pkg::SIZE_W;
  localparam int KR      = c3rb_pkg::KROW_W;
  localparam int W_RESET = (int'(c3rb_pkg::FRAME_W_RESET) > MAX_WIDTH) ?
                           MAX_WIDTH : int'(c3rb_pkg::FRAME_W_RESET);

  logic                run_r;
  logic [WW-1:0]       frame_w_r;
  logic [SW-1:0]       frame_h_r;
  logic [KR-1:0]       k_top_r;
  logic [KR-1:0]       k_mid_r;
  logic [KR-1:0]       k_bot_r;

  logic                cfg_fire;
  logic                restart;
  logic [WW-1:0]       w_clamp;
  logic [SW-1:0]       h_clamp;
  logic [SW-1:0]       size_val;
  logic                adv;
  logic                can_take;
  logic                in_fire;
  c3rb_pkg::job_t      job;
  logic [9*PIXEL_BITS-1:0] win;
  logic                res_valid;
  c3rb_pkg::res_t      res;
  c3rb_pkg::res_t      out_res;

  assign cfg_ready = run_r;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = cfg_fire && ((cfg_index == c3rb_pkg::CFG_FRAME_WIDTH) ||
                                  (cfg_index == c3rb_pkg::CFG_FRAME_HEIGHT));
  assign size_val  = cfg_data[SW-1:0];

  always_comb begin
    priority if (size_val == '0) begin
      w_clamp = WW'(1);
    end else if (int'(size_val) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(size_val);
    end
    priority if (size_val == '0) begin
      h_clamp = SW'(1);
    end else if (size_val > c3rb_pkg::HEIGHT_LIMIT) begin
      h_clamp = c3rb_pkg::HEIGHT_LIMIT;
    end else begin
      h_clamp = size_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      frame_w_r <= WW'(W_RESET);
      frame_h_r <= c3rb_pkg::FRAME_H_RESET;
      k_top_r   <= c3rb_pkg::KTOP_RESET;
      k_mid_r   <= c3rb_pkg::KMID_RESET;
      k_bot_r   <= c3rb_pkg::KBOT_RESET;
    end else begin
      run_r <= 1'b1;
      if (cfg_fire) begin
        unique case (cfg_index)
          c3rb_pkg::CFG_FRAME_WIDTH:  frame_w_r <= w_clamp;
          c3rb_pkg::CFG_FRAME_HEIGHT: frame_h_r <= h_clamp;
          c3rb_pkg::CFG_KERNEL_TOP:   k_top_r   <= cfg_data[KR-1:0];
          c3rb_pkg::CFG_KERNEL_MID:   k_mid_r   <= cfg_data[KR-1:0];
          c3rb_pkg::CFG_KERNEL_BOT:   k_bot_r   <= cfg_data[KR-1:0];
          default:                    ;
        endcase
      end
    end
  end

  assign in_tready = run_r && adv && can_take;
  assign in_fire   = in_tvalid && in_tready;

  c3rb_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .restart  (restart),
    .in_fire  (in_fire),
    .in_func  (in_tuser),
    .in_pix   (in_tdata[PIXEL_BITS-1:0]),
    .frame_w  (frame_w_r),
    .frame_h  (frame_h_r),
    .can_take (can_take),
    .job      (job),
    .win      (win)
  );

  c3rb_mac #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .job       (job),
    .win       (win),
    .k_top     (k_top_r),
    .k_mid     (k_mid_r),
    .k_bot     (k_bot_r),
    .res_valid (res_valid),
    .res       (res)
  );

  c3rb_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && res_valid),
    .push_res  (res),
    .pop       (out_tvalid && out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .room      (adv)
  );

  assign out_tdata = {{(c3rb_pkg::OUT_TDATA_W - c3rb_pkg::OUT_W){1'b0}}, out_res.value};
  assign out_tlast = out_res.last_in_run;
  assign out_tuser = out_res.last_of_frame;

endmodule

>>> sv/c3rb_checker.sv
// Port-level checks for the 3x3 convolution block, bound to the top level.
`include "conv3x3_replicate_border_defines.svh"

module c3rb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [c3rb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic                             out_tuser
);

  `C3RB_ASSERT_IMP(a_frame_end_ends_run, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  `C3RB_ASSERT_NXT_ANY(a_reset_empties_queue, clk, !rst_n, !out_tvalid)
  `C3RB_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

endmodule

bind conv3x3_replicate_border c3rb_checker u_c3rb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
